[design/sntf_pkg.sv]
// shared types, constants and divide-step helpers for the scale-to-frequency block
package sntf_pkg;

    localparam int SCALE_MAX = 16;
    localparam int DIV_MAX   = 32;
    localparam int STEP_AW   = $clog2(SCALE_MAX);
    localparam int FREQ_AW   = $clog2(DIV_MAX);

    // field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 5;
    localparam int VAL_W   = 16;
    localparam int NOTE_W  = 10;
    localparam int SSIZE_W = 5;
    localparam int DIVS_W  = 6;
    localparam int BASE_W  = 7;
    localparam int STEP_W  = 5;
    localparam int PITCH_W = 16;
    localparam int FREQ_W  = 32;
    localparam int OCT_W   = 10;
    localparam int OCT2_W  = 11;

    // dividend is note + 512 * scale_size, always non-negative
    localparam int NUM_W   = 14;
    localparam int HALF_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_WR_STEP = 2'd0,
        OP_WR_FREQ = 2'd1,
        OP_CONVERT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_SCALE_SIZE = 2'd0,
        REG_DIVISIONS  = 2'd1,
        REG_BASE_PITCH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } item_t;

    // handed from the note divider to the pitch stages
    typedef struct packed {
        item_t                    item;
        logic [STEP_AW-1:0]       deg;
        logic signed [OCT_W-1:0]  oct;
    } div_out_t;

    // handed from the pitch stages to the output shifter
    typedef struct packed {
        op_t                      op;
        logic [PITCH_W-1:0]       pitch;
        logic signed [OCT2_W-1:0] oct2;
        logic [VAL_W-1:0]         entry;
    } pitch_out_t;

    // one restoring step, 5-bit divisor: {quotient bit, new remainder}
    function automatic logic [SSIZE_W:0] div_step5(input logic [SSIZE_W-1:0] rem,
                                                   input logic bit_in,
                                                   input logic [SSIZE_W-1:0] dvs);
        logic [SSIZE_W-1:0] t;
        t = {rem[SSIZE_W-2:0], bit_in};
        if (t >= dvs) begin
            return {1'b1, t - dvs};
        end
        return {1'b0, t};
    endfunction

    // one restoring step, 6-bit divisor
    function automatic logic [DIVS_W:0] div_step6(input logic [DIVS_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [DIVS_W-1:0] dvs);
        logic [DIVS_W-1:0] t;
        t = {rem[DIVS_W-2:0], bit_in};
        if (t >= dvs) begin
            return {1'b1, t - dvs};
        end
        return {1'b0, t};
    endfunction

endpackage

[design/sntf_note_div.sv]
// two-stage floor divider of the note by the scale size
module sntf_note_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sntf_pkg::item_t                   in_item,
    input  logic signed [sntf_pkg::NOTE_W-1:0] in_note,
    input  logic [sntf_pkg::SSIZE_W-1:0]      s_eff,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sntf_pkg::div_out_t                out_data
);
    import sntf_pkg::*;

    logic                a_valid_reg;
    item_t               a_item_reg;
    logic [SSIZE_W-1:0]  a_rem_reg;
    logic [HALF_W-1:0]   a_qhi_reg;
    logic [HALF_W-1:0]   a_low_reg;
    logic [SSIZE_W-1:0]  a_rem_next;
    logic [HALF_W-1:0]   a_qhi_next;
    logic [NUM_W-1:0]    num;

    logic                b_valid_reg;
    div_out_t            b_data_reg;
    div_out_t            b_data_next;

    logic                en_a;
    logic                en_b;

    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // upper seven quotient bits
    always_comb begin
        logic [SSIZE_W:0] st;
        num = {{(NUM_W-NOTE_W){in_note[NOTE_W-1]}}, in_note}
            + {s_eff, 9'b0};
        a_rem_next = '0;
        a_qhi_next = '0;
        for (int i = HALF_W - 1; i >= 0; i--) begin
            st = div_step5(a_rem_next, num[HALF_W + i], s_eff);
            a_qhi_next[i] = st[SSIZE_W];
            a_rem_next = st[SSIZE_W-1:0];
        end
    end

    // lower seven quotient bits, then undo the 512 octave offset
    always_comb begin
        logic [SSIZE_W:0]   st;
        logic [SSIZE_W-1:0] r;
        logic [HALF_W-1:0]  qlo;
        logic [NUM_W-1:0]   q;
        r   = a_rem_reg;
        qlo = '0;
        for (int i = HALF_W - 1; i >= 0; i--) begin
            st = div_step5(r, a_low_reg[i], s_eff);
            qlo[i] = st[SSIZE_W];
            r = st[SSIZE_W-1:0];
        end
        q = {a_qhi_reg, qlo};
        b_data_next.item = a_item_reg;
        b_data_next.deg  = r[STEP_AW-1:0];
        b_data_next.oct  = {~q[OCT_W-1], q[OCT_W-2:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (en_a) begin
                a_valid_reg <= in_valid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
        end
        if (en_a) begin
            a_item_reg <= in_item;
            a_rem_reg  <= a_rem_next;
            a_qhi_reg  <= a_qhi_next;
            a_low_reg  <= num[HALF_W-1:0];
        end
        if (en_b) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

[design/sntf_pitch.sv]
// scale and frequency tables, pitch sum and table index, two register stages
module sntf_pitch (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sntf_pkg::div_out_t            in_data,
    input  logic [sntf_pkg::DIVS_W-1:0]   d_eff,
    input  logic [sntf_pkg::BASE_W-1:0]   base_pitch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sntf_pkg::pitch_out_t          out_data
);
    import sntf_pkg::*;

    logic [STEP_W-1:0] scale_steps [SCALE_MAX];
    logic [VAL_W-1:0]  freq_table  [DIV_MAX];

    logic                     c_valid_reg;
    item_t                    c_item_reg;
    logic [STEP_W-1:0]        c_step_reg;
    logic [FREQ_AW-1:0]       c_fi_reg;
    logic [STEP_W-1:0]        c_q2_reg;
    logic signed [OCT_W-1:0]  c_oct_reg;
    logic [STEP_W-1:0]        c_step_next;
    logic [FREQ_AW-1:0]       c_fi_next;
    logic [STEP_W-1:0]        c_q2_next;

    logic                     d_valid_reg;
    pitch_out_t               d_data_reg;
    pitch_out_t               d_data_next;

    logic                     en_c;
    logic                     en_d;

    assign en_d     = !d_valid_reg || out_ready;
    assign en_c     = !c_valid_reg || en_d;
    assign in_ready = en_c;

    // step lookup and step / divisions, which splits the step into index and octave carry
    always_comb begin
        logic [DIVS_W:0]   st;
        logic [DIVS_W-1:0] r;
        c_step_next = scale_steps[in_data.deg];
        r = '0;
        c_q2_next = '0;
        for (int i = STEP_W - 1; i >= 0; i--) begin
            st = div_step6(r, c_step_next[i], d_eff);
            c_q2_next[i] = st[DIVS_W];
            r = st[DIVS_W-1:0];
        end
        c_fi_next = r[FREQ_AW-1:0];
    end

    always_comb begin
        logic signed [PITCH_W:0] prod;
        prod = c_oct_reg * $signed({1'b0, d_eff});
        d_data_next.op    = c_item_reg.op;
        d_data_next.pitch = prod[PITCH_W-1:0]
                          + {{(PITCH_W-STEP_W){1'b0}}, c_step_reg}
                          + {{(PITCH_W-BASE_W){1'b0}}, base_pitch};
        d_data_next.oct2  = {c_oct_reg[OCT_W-1], c_oct_reg}
                          + {{(OCT2_W-STEP_W){1'b0}}, c_q2_reg};
        d_data_next.entry = freq_table[c_fi_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (en_c) begin
                c_valid_reg <= in_valid;
            end
            if (en_d) begin
                d_valid_reg <= c_valid_reg;
            end
        end
        if (en_c) begin
            c_item_reg <= in_data.item;
            c_step_reg <= c_step_next;
            c_fi_reg   <= c_fi_next;
            c_q2_reg   <= c_q2_next;
            c_oct_reg  <= in_data.oct;
        end
        if (en_d) begin
            d_data_reg <= d_data_next;
        end
        // table writes happen where the tables are read, keeping item order
        if (en_c && in_valid && in_data.item.op == OP_WR_STEP
                && {1'b0, in_data.item.idx} < (IDX_W+1)'(SCALE_MAX)) begin
            scale_steps[in_data.item.idx[STEP_AW-1:0]] <= in_data.item.val[STEP_W-1:0];
        end
        if (en_d && c_valid_reg && c_item_reg.op == OP_WR_FREQ
                && {1'b0, c_item_reg.idx} < (IDX_W+1)'(DIV_MAX)) begin
            freq_table[c_item_reg.idx[FREQ_AW-1:0]] <= c_item_reg.val;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

[design/sntf_freq_out.sv]
// octave shift with saturation and the output register
module sntf_freq_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sntf_pkg::pitch_out_t          in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sntf_pkg::PITCH_W-1:0]  out_pitch,
    output logic [sntf_pkg::FREQ_W-1:0]   out_freq,
    output logic                          out_sat
);
    import sntf_pkg::*;

    logic                m_valid_reg;
    logic [PITCH_W-1:0]  m_pitch_reg;
    logic [FREQ_W-1:0]   m_freq_reg;
    logic                m_sat_reg;
    logic [FREQ_W-1:0]   freq_next;
    logic                sat_next;
    logic                en_m;

    assign en_m     = !m_valid_reg || out_ready;
    assign in_ready = en_m;

    always_comb begin
        logic [FREQ_W+VAL_W-1:0] wide;
        logic [OCT2_W-1:0]       sh;
        wide      = '0;
        sh        = -in_data.oct2;
        freq_next = '0;
        sat_next  = 1'b0;
        if (in_data.entry == '0) begin
            freq_next = '0;
        end else if (!in_data.oct2[OCT2_W-1]) begin
            if (in_data.oct2[OCT2_W-2:5] != '0) begin
                freq_next = '1;
                sat_next  = 1'b1;
            end else begin
                wide = {{FREQ_W{1'b0}}, in_data.entry} << in_data.oct2[4:0];
                if (wide[FREQ_W+VAL_W-1:FREQ_W] != '0) begin
                    freq_next = '1;
                    sat_next  = 1'b1;
                end else begin
                    freq_next = wide[FREQ_W-1:0];
                end
            end
        end else if (sh[OCT2_W-1:5] == '0) begin
            freq_next = {{(FREQ_W-VAL_W){1'b0}}, in_data.entry} >> sh[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_m) begin
            // write items end here without a result word
            m_valid_reg <= in_valid && in_data.op == OP_CONVERT;
        end
        if (en_m) begin
            m_pitch_reg <= in_data.pitch;
            m_freq_reg  <= freq_next;
            m_sat_reg   <= sat_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_pitch = m_pitch_reg;
    assign out_freq  = m_freq_reg;
    assign out_sat   = m_sat_reg;

endmodule

[design/scale_note_to_frequency.sv]
// top level: scale degree to frequency converter with table loading and register port
//
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: operation, tdata: index, value, note
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pitch, frequency, tuser: saturated
//  apb       in         psel & penable, pready = 1     scale_size, divisions, base_pitch
//
// five register stages: two for note / scale_size, one for step lookup and step / divisions,
// one for the pitch multiply-add and frequency lookup, one for the octave shift (output)
// one word accepted per cycle while the output is not stalled; a convert word's result is
// offered once it has passed through all five register stages above
// table writes ride the pipeline and land at the stage that reads that table, so order holds
// each stage refills when its successor moves on, so bubbles close up under a stall
// aresetn (synchronous) empties the pipeline and restores registers to 7, 12, 0; tables keep
// their contents
module scale_note_to_frequency (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [4:0] index, [20:5] value, [30:21] note, [31] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] pitch, [47:16] frequency
    output logic        m_axis_tuser,   // [0] saturated
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sntf_pkg::*;

    // registers as written, clamped below before use
    logic [SSIZE_W-1:0] scale_size_reg;
    logic [DIVS_W-1:0]  divisions_reg;
    logic [BASE_W-1:0]  base_pitch_reg;
    logic [SSIZE_W-1:0] s_eff;
    logic [DIVS_W-1:0]  d_eff;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    item_t              in_item;
    logic               div_valid;
    logic               div_ready;
    div_out_t           div_data;
    logic               pit_valid;
    logic               pit_ready;
    pitch_out_t         pit_data;
    logic [PITCH_W-1:0] out_pitch;
    logic [FREQ_W-1:0]  out_freq;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // low address bits ignored, word index only
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_size_reg <= SSIZE_W'(7);
            divisions_reg  <= DIVS_W'(12);
            base_pitch_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCALE_SIZE: scale_size_reg <= pwdata[SSIZE_W-1:0];
                REG_DIVISIONS:  divisions_reg  <= pwdata[DIVS_W-1:0];
                REG_BASE_PITCH: base_pitch_reg <= pwdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCALE_SIZE: prdata = {{(32-SSIZE_W){1'b0}}, scale_size_reg};
            REG_DIVISIONS:  prdata = {{(32-DIVS_W){1'b0}}, divisions_reg};
            REG_BASE_PITCH: prdata = {{(32-BASE_W){1'b0}}, base_pitch_reg};
            default:        prdata = '0;
        endcase
    end

    // zero reads as one, oversize clamps to the table depth
    always_comb begin
        if (scale_size_reg == '0) begin
            s_eff = SSIZE_W'(1);
        end else if (scale_size_reg > SSIZE_W'(SCALE_MAX)) begin
            s_eff = SSIZE_W'(SCALE_MAX);
        end else begin
            s_eff = scale_size_reg;
        end
        if (divisions_reg == '0) begin
            d_eff = DIVS_W'(1);
        end else if (divisions_reg > DIVS_W'(DIV_MAX)) begin
            d_eff = DIVS_W'(DIV_MAX);
        end else begin
            d_eff = divisions_reg;
        end
    end

    // operation 3 passes through as a word that does nothing
    assign in_item.op  = op_t'(s_axis_tuser);
    assign in_item.idx = s_axis_tdata[4:0];
    assign in_item.val = s_axis_tdata[20:5];

    sntf_note_div u_note_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .in_note   (s_axis_tdata[30:21]),
        .s_eff     (s_eff),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    sntf_pitch u_pitch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_data    (div_data),
        .d_eff      (d_eff),
        .base_pitch (base_pitch_reg),
        .out_valid  (pit_valid),
        .out_ready  (pit_ready),
        .out_data   (pit_data)
    );

    sntf_freq_out u_freq_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pit_valid),
        .in_ready  (pit_ready),
        .in_data   (pit_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pitch (out_pitch),
        .out_freq  (out_freq),
        .out_sat   (m_axis_tuser)
    );

    assign m_axis_tdata = {out_freq, out_pitch};

endmodule
